// ===== hdl/urp_pkg.sv =====
// Package for the ultrasonic ranger: configuration and result types,
// register address codes and timing constants. No dependencies.
package urp_pkg;

   localparam int unsigned PeriodWidth    = 20;
   localparam int unsigned DistWidth      = 11;
   localparam int unsigned CountWidth     = 8;
   localparam int unsigned WidthUsWidth   = 16;
   localparam int unsigned SubTickWidth   = 6;
   localparam int unsigned AddrWidth      = 4;
   localparam int unsigned CsrDataWidth   = 32;

   localparam logic [SubTickWidth-1:0] CmTicks     = 6'd58;
   localparam logic [PeriodWidth-1:0]  TrigLowUs   = 20'd20;
   localparam logic [PeriodWidth-1:0]  TrigHighUs  = 20'd20;
   localparam logic [WidthUsWidth-1:0] WidthMax    = 16'hFFFF;
   localparam logic [CountWidth-1:0]   NearMax     = 8'hFF;

   localparam logic [PeriodWidth-1:0] PeriodReset    = 20'd60000;
   localparam logic [DistWidth-1:0]   ThresholdReset = 11'd15;
   localparam logic [CountWidth-1:0]  LimitReset     = 8'd5;

   localparam logic [1:0] RegTriggerPeriod = 2'd0;
   localparam logic [1:0] RegNearThreshold = 2'd1;
   localparam logic [1:0] RegNearLimit     = 2'd2;

   typedef struct packed {
      logic [PeriodWidth-1:0] trigger_period_us;
      logic [DistWidth-1:0]   near_threshold_cm;
      logic [CountWidth-1:0]  near_count_limit;
   } urp_cfg_type;

   typedef struct packed {
      logic [DistWidth-1:0] range_cm;
      logic                 measure_done;
      logic                 near_flag;
   } urp_echo_rsp_type;

endpackage

// ===== hdl/urp_csr.sv =====
// Configuration register file of the ultrasonic ranger on an APB-style port.
// Depends on urp_pkg.
module urp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [urp_pkg::AddrWidth-1:0]     csr_paddr,
   input  logic [urp_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [urp_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready,
   output urp_pkg::urp_cfg_type              cfg_o
);
   import urp_pkg::*;

   urp_cfg_type cfg_ff, cfg_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg_o      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            RegTriggerPeriod: cfg_in.trigger_period_us = csr_pwdata[PeriodWidth-1:0];
            RegNearThreshold: cfg_in.near_threshold_cm = csr_pwdata[DistWidth-1:0];
            RegNearLimit:     cfg_in.near_count_limit  = csr_pwdata[CountWidth-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         RegTriggerPeriod: csr_prdata = {{(CsrDataWidth-PeriodWidth){1'b0}},
                                         cfg_ff.trigger_period_us};
         RegNearThreshold: csr_prdata = {{(CsrDataWidth-DistWidth){1'b0}},
                                         cfg_ff.near_threshold_cm};
         RegNearLimit:     csr_prdata = {{(CsrDataWidth-CountWidth){1'b0}},
                                         cfg_ff.near_count_limit};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_period_us <= PeriodReset;
         cfg_ff.near_threshold_cm <= ThresholdReset;
         cfg_ff.near_count_limit  <= LimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/urp_trigger.sv =====
// Trigger pulse generator of the ultrasonic ranger: a period counter
// advanced once per tick. Depends on urp_pkg.
module urp_trigger (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step_i,
   input  logic [urp_pkg::PeriodWidth-1:0]     period_i,
   output logic                                trigger_o
);
   import urp_pkg::*;

   logic [PeriodWidth-1:0] count_ff, count_in;
   logic [PeriodWidth:0]   count_inc;

   assign trigger_o = (count_ff >= TrigLowUs) && (count_ff < (TrigLowUs + TrigHighUs));
   assign count_inc = {1'b0, count_ff} + {{PeriodWidth{1'b0}}, 1'b1};

   always_comb begin
      count_in = count_ff;
      if (step_i) begin
         if ((period_i <= {{(PeriodWidth-1){1'b0}}, 1'b1}) ||
             (count_inc >= {1'b0, period_i})) begin
            count_in = '0;
         end else begin
            count_in = count_inc[PeriodWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_short_period_holds: assert property (@(posedge clock) disable iff (reset)
      (step_i && period_i <= 20'd1) |=> (count_ff == '0))
      else $error("period counter left zero with a period of one or less");

   a_pulse_in_window: assert property (@(posedge clock) disable iff (reset)
      (trigger_o && step_i && period_i > count_inc[PeriodWidth-1:0] && !count_inc[PeriodWidth])
      |=> (count_ff == $past(count_inc[PeriodWidth-1:0])))
      else $error("period counter skipped a tick during the pulse");

endmodule

// ===== hdl/urp_echo.sv =====
// Echo timer of the ultrasonic ranger: pulse width, centimetre conversion
// and the consecutive near count. Depends on urp_pkg.
module urp_echo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_i,
   input  logic                           echo_i,
   input  urp_pkg::urp_cfg_type           cfg_i,
   output urp_pkg::urp_echo_rsp_type      rsp_o
);
   import urp_pkg::*;

   logic                    prev_ff, prev_in;
   logic                    armed_ff, armed_in;
   logic [WidthUsWidth-1:0] width_ff, width_in;
   logic [SubTickWidth-1:0] sub_ff, sub_in;
   logic [DistWidth-1:0]    cm_ff, cm_in;
   logic [DistWidth-1:0]    last_ff, last_in;
   logic [CountWidth-1:0]   near_ff, near_in;
   logic                    done;

   always_comb begin
      prev_in  = prev_ff;
      armed_in = armed_ff;
      width_in = width_ff;
      sub_in   = sub_ff;
      cm_in    = cm_ff;
      last_in  = last_ff;
      near_in  = near_ff;
      done     = 1'b0;
      if (step_i) begin
         prev_in = echo_i;
         if (echo_i && !prev_ff) begin
            armed_in = 1'b1;
            width_in = {{(WidthUsWidth-1){1'b0}}, 1'b1};
            sub_in   = {{(SubTickWidth-1){1'b0}}, 1'b1};
            cm_in    = '0;
         end else if (echo_i && armed_ff) begin
            if (width_ff < WidthMax) begin
               width_in = width_ff + 1'b1;
               if (sub_ff == (CmTicks - 1'b1)) begin
                  sub_in = '0;
                  cm_in  = cm_ff + 1'b1;
               end else begin
                  sub_in = sub_ff + 1'b1;
               end
            end
         end else if (!echo_i && prev_ff && armed_ff) begin
            last_in  = cm_ff;
            done     = 1'b1;
            armed_in = 1'b0;
            if (cm_ff < cfg_i.near_threshold_cm) begin
               if (near_ff < NearMax) begin
                  near_in = near_ff + 1'b1;
               end
            end else begin
               near_in = '0;
            end
         end
      end
   end

   assign rsp_o.range_cm     = last_in;
   assign rsp_o.measure_done = done;
   assign rsp_o.near_flag    = (near_in > cfg_i.near_count_limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b0;
         armed_ff <= 1'b0;
         width_ff <= '0;
         sub_ff   <= '0;
         cm_ff    <= '0;
         last_ff  <= '0;
         near_ff  <= '0;
      end else begin
         prev_ff  <= prev_in;
         armed_ff <= armed_in;
         width_ff <= width_in;
         sub_ff   <= sub_in;
         cm_ff    <= cm_in;
         last_ff  <= last_in;
         near_ff  <= near_in;
      end
   end

   a_sub_tick_range: assert property (@(posedge clock) disable iff (reset)
      sub_ff < CmTicks)
      else $error("centimetre sub-counter out of range");

   a_armed_width: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (width_ff != '0))
      else $error("armed echo timer with zero width");

   a_done_disarms: assert property (@(posedge clock) disable iff (reset)
      (step_i && done) |=> (!armed_ff && last_ff == $past(cm_ff)))
      else $error("completed measurement did not disarm the timer");

endmodule

// ===== hdl/ultrasonic_ranger_proximity_top.sv =====
// Ultrasonic ranger controller, stepped once per microsecond tick.
//
// Input stream (req_): one transfer per tick carries the sampled echo level
// in bit 0 of req_tdata. Result stream (rsp_): one transfer per input
// transfer carries the trigger level to drive, the latest distance in
// centimetres, a flag marking the tick on which a measurement completed,
// and the near flag.
// Configuration is written through the csr_ port: trigger period at 0x0,
// near threshold at 0x4, near count limit at 0x8; pready is always high.
//
// Each tick passes through an input register and a result register, from
// which its result is offered. Throughput is one tick per cycle while the
// receiver takes each result, set by the single-pass update between the
// two registers. A new tick is taken while a result waits if the input
// register is empty or can drain into the result register. Reset clears
// all state but the data registers and loads the register defaults; no
// clearing pass. When the receiver stalls, the result holds and the input
// register fills, then req_tready falls until the receiver takes the result.
module ultrasonic_ranger_proximity_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [0] echo_level, [7:1] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] trigger_level, [11:1] range_cm, [12] measure_done,
   // [13] near_flag, [15:14] zero
   output logic [15:0]                       rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [urp_pkg::AddrWidth-1:0]     csr_paddr,
   input  logic [urp_pkg::CsrDataWidth-1:0]  csr_pwdata,
   output logic [urp_pkg::CsrDataWidth-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import urp_pkg::*;

   urp_cfg_type      cfg;
   urp_echo_rsp_type echo_rsp;
   logic             trigger;
   logic             advance;
   logic             req_xfer;

   logic             in_valid_ff, in_valid_in;
   logic             in_echo_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [15:0]      rsp_data_ff;

   assign advance    = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_xfer   = req_tvalid & req_tready;

   assign in_valid_in  = req_xfer | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_tready);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   urp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg_o       (cfg)
   );

   urp_trigger u_trigger (
      .clock     (clock),
      .reset     (reset),
      .step_i    (advance),
      .period_i  (cfg.trigger_period_us),
      .trigger_o (trigger)
   );

   urp_echo u_echo (
      .clock  (clock),
      .reset  (reset),
      .step_i (advance),
      .echo_i (in_echo_ff),
      .cfg_i  (cfg),
      .rsp_o  (echo_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_echo_ff <= req_tdata[0];
      end
      if (advance) begin
         rsp_data_ff <= {2'b00, echo_rsp.near_flag, echo_rsp.measure_done,
                         echo_rsp.range_cm, trigger};
      end
   end

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("stepped tick produced no result");

   a_pending_tick_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_echo_ff)))
      else $error("pending tick lost while the result stage was blocked");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !advance)
      else $error("result overwritten before transfer");

endmodule
